>>> hw/rtl/heu_pkg.sv
package heu_pkg;

  localparam int HOLD_DEPTH  = 5;
  localparam int ENT_COUNT   = 5;
  localparam int ENT_MAX_LEN = 6;
  localparam int BURST_DEPTH = HOLD_DEPTH + 1;

  localparam logic [7:0] AMP_CHAR = 8'h26;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_string_end;
  } out_t;

  // Entity spellings, padded with zero bytes past their length.
  localparam logic [7:0] ENT_TEXT [ENT_COUNT][ENT_MAX_LEN] = '{
    '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // &amp;
    '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // &lt;
    '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // &gt;
    '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},  // &quot;
    '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b}   // &apos;
  };

  localparam logic [3:0] ENT_LEN [ENT_COUNT] = '{4'd5, 4'd4, 4'd4, 4'd6, 4'd6};

  localparam logic [7:0] ENT_VALUE [ENT_COUNT] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};

endpackage

>>> hw/rtl/html_entity_unescape_top.sv
// Results are registered: an item passes from the input register into the burst
//   register, which drives the output; a busy burst register can hold it between them.
// Throughput: one byte per cycle while each item yields at most one result and results
//   are taken; a release of held bytes holds the single output register, stalling result items.
// Reset (rst, synchronous): clears valid flags and the held count; byte storage is not cleared.
module html_entity_unescape_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  heu_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_ready,
  output heu_pkg::out_t result
);

  // Input register: one transaction waiting for evaluation.
  logic          iv;
  heu_pkg::in_t  iq;

  // Partial entity held back between items.
  logic [7:0] held [heu_pkg::HOLD_DEPTH];
  logic [2:0] held_count;

  // Burst register: results of one evaluated item, sent one per cycle while result_ready is high.
  logic       bv;
  logic [7:0] burst [heu_pkg::BURST_DEPTH];
  logic [2:0] burst_count;
  logic [2:0] burst_idx;
  logic       burst_end;

  // Evaluation of the item in the input register against the held bytes.
  logic [7:0] cand      [heu_pkg::BURST_DEPTH];
  logic [7:0] load_byte [heu_pkg::BURST_DEPTH];
  logic [heu_pkg::ENT_COUNT-1:0] ent_full;
  logic [heu_pkg::ENT_COUNT-1:0] ent_part;
  logic [7:0] full_value;
  logic [3:0] cand_len;
  logic [2:0] nres;
  logic [2:0] count_next;
  logic       hold_write;
  logic [2:0] hold_pos;
  logic       any_full;
  logic       any_part;
  logic       buf_free;
  logic       eval_go;
  logic       out_fire;
  logic       out_last;

  always_comb begin
    logic mismatch;
    cand_len = {1'b0, held_count} + 4'd1;
    // Candidate is the held bytes with the new byte placed right after them.
    for (int i = 0; i < heu_pkg::BURST_DEPTH; i++) begin
      if (i < heu_pkg::HOLD_DEPTH && i[2:0] != held_count) begin
        cand[i] = held[i];
      end else begin
        cand[i] = iq.in_byte;
      end
    end
    full_value = '0;
    for (int e = 0; e < heu_pkg::ENT_COUNT; e++) begin
      mismatch = 1'b0;
      for (int k = 0; k < heu_pkg::ENT_MAX_LEN; k++) begin
        if (k[2:0] <= held_count && cand[k] != heu_pkg::ENT_TEXT[e][k]) begin
          mismatch = 1'b1;
        end
      end
      ent_full[e] = !mismatch && cand_len == heu_pkg::ENT_LEN[e];
      ent_part[e] = !mismatch && cand_len <  heu_pkg::ENT_LEN[e];
      if (ent_full[e]) begin
        full_value = heu_pkg::ENT_VALUE[e];
      end
    end
    any_full = |ent_full;
    any_part = |ent_part && held_count < 3'(heu_pkg::HOLD_DEPTH);

    for (int i = 0; i < heu_pkg::BURST_DEPTH; i++) begin
      load_byte[i] = cand[i];
    end
    hold_write = 1'b0;
    hold_pos   = held_count;
    count_next = '0;
    if (any_full) begin
      // Entity complete: emit its character, drop the held bytes.
      load_byte[0] = full_value;
      nres         = 3'd1;
    end else if (any_part) begin
      if (!iq.string_end) begin
        // Still a prefix: hold the byte, emit nothing.
        nres       = '0;
        hold_write = 1'b1;
        count_next = held_count + 3'd1;
      end else begin
        // String ends mid-match: flush everything raw.
        nres = held_count + 3'd1;
      end
    end else if (iq.in_byte == heu_pkg::AMP_CHAR && !iq.string_end) begin
      // Match broken by a new '&': release held bytes, start over with it.
      nres       = held_count;
      hold_write = 1'b1;
      hold_pos   = '0;
      count_next = 3'd1;
    end else begin
      nres = held_count + 3'd1;
    end
  end

  assign out_last     = burst_idx == burst_count - 3'd1;
  assign out_fire     = bv && result_ready;
  assign buf_free     = !bv || (result_ready && out_last);
  assign eval_go      = iv && (nres == '0 || buf_free);
  assign item_ready   = !iv || eval_go;
  assign result_valid = bv;

  always_comb begin
    result.out_byte       = burst[burst_idx];
    result.run_last       = out_last;
    result.out_string_end = out_last && burst_end;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      iv          <= 1'b0;
      bv          <= 1'b0;
      held_count  <= '0;
      burst_idx   <= '0;
      burst_count <= '0;
    end else begin
      if (item_ready) begin
        iv <= item_valid;
      end
      if (eval_go) begin
        held_count <= count_next;
      end
      // Load a new burst, else advance or drop the current one.
      if (eval_go && nres != '0) begin
        bv          <= 1'b1;
        burst_idx   <= '0;
        burst_count <= nres;
      end else if (out_fire) begin
        if (out_last) begin
          bv <= 1'b0;
        end else begin
          burst_idx <= burst_idx + 3'd1;
        end
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      iq <= item;
    end
    if (eval_go && hold_write) begin
      for (int i = 0; i < heu_pkg::HOLD_DEPTH; i++) begin
        if (i[2:0] == hold_pos) begin
          held[i] <= iq.in_byte;
        end
      end
    end
    if (eval_go && nres != '0) begin
      for (int i = 0; i < heu_pkg::BURST_DEPTH; i++) begin
        burst[i] <= load_byte[i];
      end
      burst_end <= iq.string_end;
    end
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= 3'(heu_pkg::HOLD_DEPTH))
    else $error("held count exceeds hold depth");

  a_burst_idx: assert property (@(posedge clk) disable iff (rst)
    bv |-> (burst_count != '0 && burst_idx < burst_count))
    else $error("burst index outside burst");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (eval_go && iq.string_end) |=> held_count == '0)
    else $error("string end left bytes held");

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    (eval_go && iq.string_end) |-> nres != '0)
    else $error("string end produced no result");
`endif

endmodule

>>> dv/tb_html_entity_unescape_top.sv
module tb_html_entity_unescape_top;

  // Generous bound on the whole run: roughly 410 bytes, up to six decoded
  // characters each, with a receiver that drops ready at random or holds it off.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_OFF_SPAN = 60;

  // Characters that the five entities stand for.
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3c;
  localparam logic [7:0] CH_GT   = 8'h3e;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam int NUM_ENTITIES    = 5;

  logic          clk;
  logic          rst;
  logic          item_valid;
  logic          item_ready;
  heu_pkg::in_t  item;
  logic          result_valid;
  logic          result_ready;
  heu_pkg::out_t result;

  // Shadow of the decoder's partial-entity buffer.
  logic [7:0] held_text [heu_pkg::HOLD_DEPTH];
  int         held_len;

  // Decoded characters still owed by the DUT, oldest first.
  heu_pkg::out_t expected_chars [$];

  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_left;
  bit hold_off_req;

  html_entity_unescape_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Watchdog: a stuck handshake or a lost character ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic string entity_text(int e);
    case (e)
      0:       return "&amp;";
      1:       return "&lt;";
      2:       return "&gt;";
      3:       return "&quot;";
      default: return "&apos;";
    endcase
  endfunction

  function automatic logic [7:0] entity_char(int e);
    case (e)
      0:       return CH_AMP;
      1:       return CH_LT;
      2:       return CH_GT;
      3:       return CH_QUOT;
      default: return CH_APOS;
    endcase
  endfunction

  function automatic void owe_char(logic [7:0] c);
    heu_pkg::out_t r;
    r.out_byte       = c;
    r.run_last       = 1'b0;
    r.out_string_end = 1'b0;
    expected_chars.insert(expected_chars.size(), r);
  endfunction

  // Advance the shadow decoder by one accepted byte and queue the characters
  // it releases. The last character of the run carries run_last, and also
  // out_string_end when the byte closes the string.
  function automatic void decode_entity_byte(logic [7:0] b, logic fin);
    logic [7:0] cand [heu_pkg::HOLD_DEPTH + 1];
    string      s;
    int         n;
    int         full;
    bit         partial;
    bit         hit;
    int         last_idx;

    n = held_len;
    for (int i = 0; i < n; i++) cand[i] = held_text[i];
    cand[n] = b;

    full    = -1;
    partial = 1'b0;
    for (int e = 0; e < NUM_ENTITIES; e++) begin
      s   = entity_text(e);
      hit = (n + 1 <= s.len());
      for (int k = 0; k <= n && hit; k++) begin
        if (cand[k] != s[k]) hit = 1'b0;
      end
      if (hit) begin
        if (n + 1 == s.len()) full = e;
        else partial = 1'b1;
      end
    end

    if (full >= 0) begin
      // Entity complete: emit the single decoded character.
      owe_char(entity_char(full));
      held_len = 0;
    end else if (partial) begin
      if (!fin) begin
        // Still a prefix: hold the byte, nothing comes out.
        held_text[n] = b;
        held_len     = n + 1;
        return;
      end
      // String ends mid-entity: flush everything raw.
      for (int i = 0; i <= n; i++) owe_char(cand[i]);
      held_len = 0;
    end else begin
      // Match broken: release the held prefix raw, then restart on '&'
      // unless the string ends here.
      for (int i = 0; i < n; i++) owe_char(cand[i]);
      held_len = 0;
      if (b == CH_AMP && !fin) begin
        held_text[0] = b;
        held_len     = 1;
      end else begin
        owe_char(b);
      end
    end

    last_idx = expected_chars.size() - 1;
    expected_chars[last_idx].run_last       = 1'b1;
    expected_chars[last_idx].out_string_end = fin;
  endfunction

  // Receiver: drop ready at random, or hold it low for a long stretch when a
  // test asks for back-pressure.
  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_off_req  = 1'b0;
      hold_off_left = HOLD_OFF_SPAN;
    end
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare every output transaction against the oldest owed character.
  always @(posedge clk) begin
    heu_pkg::out_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result: out_byte %h run_last %b out_string_end %b",
               result.out_byte, result.run_last, result.out_string_end);
        mismatch_count++;
      end else begin
        want = expected_chars.pop_front();
        if (result.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, result.out_byte);
          mismatch_count++;
        end
        if (result.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, result.run_last);
          mismatch_count++;
        end
        if (result.out_string_end !== want.out_string_end) begin
          $error("out_string_end: expected %b, got %b",
                 want.out_string_end, result.out_string_end);
          mismatch_count++;
        end
      end
    end
  end

  task automatic reset_dut();
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    held_len = 0;
  endtask

  // Offer one byte and hold it until the input transaction completes.
  // Entered and left on a falling edge.
  task automatic send_byte(logic [7:0] b, logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= {b, fin};
    do @(posedge clk); while (!item_ready);
    decode_entity_byte(b, fin);
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit end_on_last);
    for (int k = 0; k < s.len(); k++) send_byte(s[k], end_on_last && (k == s.len() - 1));
  endtask

  // Hand-picked strings: every decode path, the deepest release, a 0xFF
  // byte, and both ways a string can end mid-entity.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Longest entity decodes to one character.
    send_text("&quot;", 1'b0);
    // Full five-byte prefix broken by 0xFF: six raw characters.
    send_text("&apos", 1'b0);
    send_byte(8'hff, 1'b0);
    // A new '&' breaks the match and starts the next entity.
    send_text("&am&lt;", 1'b0);
    // String ends while still a prefix: flush raw.
    send_text("&gt", 1'b1);
    // String ends on an '&' that breaks the match: flush it raw too.
    send_text("&a&", 1'b1);
  endtask

  // Random text built mostly from whole and cut-short entities, with some
  // noise from the entity alphabet and some fully random bytes.
  task automatic send_random_text(int n_bytes);
    logic [7:0] token [$];
    string      s;
    string      letters;
    int         sent;
    int         pick;
    int         cut;

    letters = "&amp;ltgquos";
    sent    = 0;
    while (sent < n_bytes) begin
      token.delete();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        s = entity_text($urandom_range(0, NUM_ENTITIES - 1));
        for (int k = 0; k < s.len(); k++) token.insert(token.size(), s[k]);
      end else if (pick < 65) begin
        s   = entity_text($urandom_range(0, NUM_ENTITIES - 1));
        cut = $urandom_range(1, s.len() - 1);
        for (int k = 0; k < cut; k++) token.insert(token.size(), s[k]);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4))
          token.insert(token.size(), letters[$urandom_range(0, letters.len() - 1)]);
      end else begin
        repeat ($urandom_range(1, 4)) token.insert(token.size(), 8'($urandom_range(0, 255)));
      end
      foreach (token[k]) begin
        send_byte(token[k], $urandom_range(0, 11) == 0);
        sent++;
      end
    end
  endtask

  task automatic test_random_text(int n_bytes, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    send_random_text(n_bytes);
  endtask

  // Hold the receiver off while the sender keeps offering bytes, so the
  // output register fills and the input stalls.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 1'b1;
    send_random_text(25);
  endtask

  task automatic wait_drained();
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    item_valid     = 1'b0;
    item           = '0;
    result_ready   = 1'b0;
    held_len       = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_off_left  = 0;
    hold_off_req   = 1'b0;

    reset_dut();
    test_directed_cases();
    test_random_text(120, 26, 64);
    test_random_text(120, 64, 26);
    test_random_text(120, 0, 0);
    test_output_stall();
    item_valid <= 1'b0;
    wait_drained();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> html_entity_unescape_top.f
hw/rtl/heu_pkg.sv
hw/rtl/html_entity_unescape_top.sv
dv/tb_html_entity_unescape_top.sv
